### hw/rtl/cgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cgc_pkg;

	localparam int PHASE_W    = 32;
	localparam int IDX_W      = 12;
	localparam int FRAC_W     = PHASE_W - IDX_W;
	localparam int KEY_IDX_W  = 4;
	localparam int POS_W      = KEY_IDX_W + IDX_W;
	localparam int CH_W       = 8;
	localparam int CHANNELS   = 3;
	localparam int ENTRIES    = 2;
	localparam int PIX_W      = 32;

	localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

	typedef logic [CH_W*CHANNELS-1:0] rgb_t;

	// key colors along the cycle, last one equals the first
	function automatic rgb_t key_color(input logic [KEY_IDX_W-1:0] k);
		rgb_t c;
		case (k)
			4'd0:    c = 24'h0E0B52;
			4'd1:    c = 24'h0E3CA5;
			4'd2:    c = 24'h4E9ADC;
			4'd3:    c = 24'hB0E5FF;
			4'd4:    c = 24'hF9FDEF;
			4'd5:    c = 24'hF9E560;
			4'd6:    c = 24'hF9B50F;
			4'd7:    c = 24'hD96C03;
			4'd8:    c = 24'h86200D;
			4'd9:    c = 24'h390423;
			4'd10:   c = 24'h0E0B52;
			default: c = 24'h0E0B52;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/cyclic_gradient_colormap.sv
// cyclic_gradient_colormap
//
// maps one phase per pixel (unsigned 0.32 fraction of a full color cycle) to
// an opaque ARGB pixel: alpha 0xFF, red 23-16, green 15-8, blue 7-0
// input channel: in_valid / in_stall / phase; output channel: out_valid /
// out_stall / pixel_argb; a request moves when valid is high and stall is low
// the 4096-entry gradient is not stored: each of the two neighbor entries is
// rebuilt on the fly from the eleven key colors, then blended by the low 20
// phase bits with round half up
// five register stages: index decode, key fetch and entry product, entry
// rounding, blend product, blend rounding into the output register
// one request per cycle sustained while out_stall is low
// each stage holds its request when the next one is full and stalled, so
// empty stages keep filling while a result waits; in_stall rises only when
// all five stages hold requests and out_stall is high
// reset clears all valid bits; the pipeline is empty and ready right after
`timescale 1ns / 1ps
`default_nettype none

module cyclic_gradient_colormap (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [cgc_pkg::PHASE_W-1:0]  phase,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [cgc_pkg::PIX_W-1:0]    pixel_argb
);
	import cgc_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;

	// stage 1 registers
	logic [KEY_IDX_W-1:0] k_s1    [ENTRIES];
	logic [IDX_W-1:0]     r_s1    [ENTRIES];
	logic [FRAC_W-1:0]    frac_s1;

	// stage 2 registers
	logic [CH_W-1:0]      base_s2 [ENTRIES][CHANNELS];
	logic signed [21:0]   prod_s2 [ENTRIES][CHANNELS];
	logic [FRAC_W-1:0]    frac_s2;

	// stage 3 registers
	logic [CH_W-1:0]      ent_s3  [ENTRIES][CHANNELS];
	logic [FRAC_W-1:0]    frac_s3;

	// stage 4 registers
	logic [CH_W-1:0]      base_s4 [CHANNELS];
	logic signed [29:0]   prod_s4 [CHANNELS];

	// stage 5 registers
	logic [CH_W-1:0]      rgb_s5  [CHANNELS];

	// combinational results of each stage
	logic [IDX_W-1:0]     idx_d   [ENTRIES];
	logic [POS_W-1:0]     pos_d   [ENTRIES];
	logic [CH_W-1:0]      base_d2 [ENTRIES][CHANNELS];
	logic signed [21:0]   prod_d2 [ENTRIES][CHANNELS];
	logic [CH_W-1:0]      ent_d3  [ENTRIES][CHANNELS];
	logic signed [29:0]   prod_d4 [CHANNELS];
	logic [CH_W-1:0]      rgb_d5  [CHANNELS];

	assign ready_s5 = !valid_s5 || !out_stall;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	// entry index and its cyclic successor, position along the ten segments
	always_comb begin
		idx_d[0] = phase[PHASE_W-1 -: IDX_W];
		idx_d[1] = idx_d[0] + {{(IDX_W-1){1'b0}}, 1'b1};
		for (int e = 0; e < ENTRIES; e++) begin
			pos_d[e] = {1'b0, idx_d[e], 3'b000} + {3'b000, idx_d[e], 1'b0};
		end
	end

	// key fetch and segment weight product
	always_comb begin
		rgb_t            ka;
		rgb_t            kb;
		logic signed [8:0] diff;
		for (int e = 0; e < ENTRIES; e++) begin
			ka = key_color(k_s1[e]);
			kb = key_color(k_s1[e] + 4'd1);
			for (int c = 0; c < CHANNELS; c++) begin
				base_d2[e][c] = ka[16-8*c +: CH_W];
				diff = $signed({1'b0, kb[16-8*c +: CH_W]}) - $signed({1'b0, ka[16-8*c +: CH_W]});
				prod_d2[e][c] = diff * $signed({1'b0, r_s1[e]});
			end
		end
	end

	// entry rounding
	always_comb begin
		logic signed [22:0] sum;
		for (int e = 0; e < ENTRIES; e++) begin
			for (int c = 0; c < CHANNELS; c++) begin
				sum = $signed({3'b000, base_s2[e][c], 12'h000})
					+ $signed({prod_s2[e][c][21], prod_s2[e][c]})
					+ 23'sd2048;
				ent_d3[e][c] = sum[19:12];
			end
		end
	end

	// blend product between neighbor entries
	always_comb begin
		logic signed [8:0] diff;
		for (int c = 0; c < CHANNELS; c++) begin
			diff = $signed({1'b0, ent_s3[1][c]}) - $signed({1'b0, ent_s3[0][c]});
			prod_d4[c] = diff * $signed({1'b0, frac_s3});
		end
	end

	// blend rounding, half up
	always_comb begin
		logic signed [30:0] sum;
		for (int c = 0; c < CHANNELS; c++) begin
			sum = $signed({3'b000, base_s4[c], 20'h00000})
				+ $signed({prod_s4[c][29], prod_s4[c]})
				+ 31'sd524288;
			rgb_d5[c] = sum[27:20];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			for (int e = 0; e < ENTRIES; e++) begin
				k_s1[e] <= pos_d[e][POS_W-1 -: KEY_IDX_W];
				r_s1[e] <= pos_d[e][IDX_W-1:0];
			end
			frac_s1 <= phase[FRAC_W-1:0];
		end
		if (ready_s2) begin
			base_s2 <= base_d2;
			prod_s2 <= prod_d2;
			frac_s2 <= frac_s1;
		end
		if (ready_s3) begin
			ent_s3  <= ent_d3;
			frac_s3 <= frac_s2;
		end
		if (ready_s4) begin
			base_s4 <= ent_s3[0];
			prod_s4 <= prod_d4;
		end
		if (ready_s5) begin
			rgb_s5 <= rgb_d5;
		end
	end

	assign out_valid  = valid_s5;
	assign pixel_argb = {ALPHA_OPAQUE, rgb_s5[0], rgb_s5[1], rgb_s5[2]};

endmodule

`default_nettype wire

### hw/rtl/cgc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cgc_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         in_valid,
	input wire                         in_stall,
	input wire [cgc_pkg::PHASE_W-1:0]  phase,
	input wire                         out_valid,
	input wire                         out_stall,
	input wire [cgc_pkg::PIX_W-1:0]    pixel_argb
);
	import cgc_pkg::*;

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_argb))
		else $error("stalled result changed");

	// every pixel is opaque
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_argb[PIX_W-1 -: CH_W] == ALPHA_OPAQUE)
		else $error("alpha not opaque");

	// an empty output stage never backs up the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// with the output free-flowing, phase zero comes out as the first key color
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && phase == '0) ##1 !out_stall ##1 !out_stall
			##1 !out_stall ##1 !out_stall
		|=> out_valid && pixel_argb == 32'hFF0E0B52)
		else $error("phase zero result wrong or late");

endmodule

bind cyclic_gradient_colormap cgc_checker u_cgc_checker (.*);

`default_nettype wire
